// File: rtl/hba_pkg.sv
`timescale 1ns / 1ps
package hba_pkg;
    localparam int MAX_BLOCKS   = 64;
    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 24;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int ENT_W        = 16 + 17 + 1;

    localparam logic [2:0] ST_DONE  = 3'd0;
    localparam logic [2:0] ST_ZERO  = 3'd1;
    localparam logic [2:0] ST_HEAP  = 3'd2;
    localparam logic [2:0] ST_TABLE = 3'd3;
    localparam logic [2:0] ST_BAD   = 3'd4;
    localparam logic [2:0] ST_NULL  = 3'd5;

    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [0:0] REG_POLICY = 1'b0;
    localparam logic [0:0] REG_LIMIT  = 1'b1;

    typedef struct packed {
        logic [15:0] start;
        logic [16:0] len;
        logic        free;
    } t_entry;
endpackage

// File: rtl/hba_ram.sv
`timescale 1ns / 1ps
module hba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/heap_block_allocator_top.sv
`timescale 1ns / 1ps
// channel | dir | fields
// s_axis  | in  | tuser: mode[0]; tdata: request_bytes[15:0], release_address[31:16]
// m_axis  | out | tdata: status[2:0], data_address[18:3], granted_bytes[35:19]
// apb     | in  | 0x0 fit_policy, 0x4 heap_limit
// allocate: each table entry is read and checked in turn, then on a split every entry
// above the picked one is moved up one slot before the remainder is written behind it
// release: one read-merge-write pass over the table entries
// zero and null requests go straight to the output register
// reset is synchronous and needs no clearing pass
// a result waits in the output register; the next transaction is taken once it is gone
module heap_block_allocator_top
    import hba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tuser,   // mode
    input  logic [31:0] s_axis_tdata,   // request_bytes, release_address
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // status, data_address, granted_bytes
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [3:0] {
        S_IDLE, S_SRD, S_SCHK, S_PICK, S_SHRD, S_SHWR, S_SPLIT,
        S_MRD, S_MCHK, S_FLUSH, S_OUT
    } t_state;

    t_state            r_state;
    logic [1:0]        r_policy;
    logic [16:0]       r_limit;
    logic [CNT_W-1:0]  r_count;
    logic [16:0]       r_top;
    logic              r_mode;
    logic [16:0]       r_size;
    logic [15:0]       r_addr;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_w;
    logic              r_found;
    logic [IDX_W-1:0]  r_pick;
    logic [16:0]       r_pdiff;
    t_entry            r_pent;
    t_entry            r_acc;
    logic              r_have;
    logic [2:0]        r_st;
    logic [15:0]       r_da;
    logic [16:0]       r_gb;

    logic              we;
    logic [IDX_W-1:0]  waddr, raddr;
    t_entry            wdata, rd;
    logic [ENT_W-1:0]  rd_raw;

    hba_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rd_raw)
    );
    assign rd = t_entry'(rd_raw);

    logic        cfg_wr;
    logic [16:0] hend;
    logic [16:0] diff;
    logic        fits;
    logic [17:0] grow_end;
    logic [16:0] left;

    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_LIMIT) ? {15'd0, r_limit} : {30'd0, r_policy};
    assign hend    = (r_limit > 17'(HEAP_BYTES)) ? 17'(HEAP_BYTES) : r_limit;
    assign diff    = rd.len - r_size;
    assign fits    = rd.free && (rd.len >= r_size);
    assign grow_end = {1'b0, r_top} + 18'(HEADER_BYTES) + {1'b0, r_size};
    assign left    = r_pent.len - r_size;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {4'd0, r_gb, r_da, r_st};

    always_comb begin
        we    = 1'b0;
        waddr = r_w[IDX_W-1:0];
        wdata = r_acc;
        raddr = r_i[IDX_W-1:0];
        case (r_state)
            S_SHWR: begin
                we    = 1'b1;
                waddr = IDX_W'(r_i + 1'b1);
                wdata = rd;
            end
            S_SPLIT: begin
                we    = 1'b1;
                waddr = IDX_W'(r_pick + 1'b1);
                wdata.start = 16'(r_pent.start + 16'(HEADER_BYTES) + r_size[15:0]);
                wdata.len   = 17'(left - 17'(HEADER_BYTES));
                wdata.free  = 1'b1;
            end
            S_PICK: begin
                waddr = r_found ? r_pick : r_count[IDX_W-1:0];
                wdata.start = r_found ? r_pent.start : r_top[15:0];
                wdata.len   = (r_found && !(left > 17'(HEADER_BYTES)
                               && r_count < CNT_W'(MAX_BLOCKS))) ? r_pent.len : r_size;
                wdata.free  = 1'b0;
                we    = r_found || (r_count < CNT_W'(MAX_BLOCKS) && grow_end <= {1'b0, hend});
            end
            S_MCHK: begin
                we    = r_have && !(r_acc.free && rd.free);
                waddr = r_w[IDX_W-1:0];
            end
            S_FLUSH: we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_policy <= '0;
            r_limit  <= 17'd65536;
            r_count  <= '0;
            r_top    <= '0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_POLICY) r_policy <= pwdata[1:0];
                else r_limit <= pwdata[16:0];
            end
            case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_mode  <= (s_axis_tuser == MODE_FREE);
                    r_size  <= 17'({1'b0, s_axis_tdata[15:0]} + 17'd3) & ~17'd3;
                    r_addr  <= s_axis_tdata[31:16];
                    r_i     <= '0;
                    r_w     <= '0;
                    r_found <= 1'b0;
                    r_have  <= 1'b0;
                    r_da    <= '0;
                    r_gb    <= '0;
                    if (s_axis_tuser == MODE_ALLOC && s_axis_tdata[15:0] == 16'd0) begin
                        r_st <= ST_ZERO; r_state <= S_OUT;
                    end else if (s_axis_tuser == MODE_FREE && s_axis_tdata[31:16] == 16'd0) begin
                        r_st <= ST_NULL; r_state <= S_OUT;
                    end else begin
                        r_state <= (s_axis_tuser == MODE_FREE) ? S_MRD : S_SRD;
                    end
                end
                S_SRD: r_state <= (r_i == r_count) ? S_PICK : S_SCHK;
                S_SCHK: begin
                    if (fits && (!r_found || (r_policy == POL_BEST && diff < r_pdiff)
                                 || (r_policy == POL_WORST && diff > r_pdiff))) begin
                        r_found <= 1'b1;
                        r_pick  <= r_i[IDX_W-1:0];
                        r_pdiff <= diff;
                        r_pent  <= rd;
                    end
                    if (fits && r_policy != POL_BEST && r_policy != POL_WORST
                        && !r_found) begin
                        r_i <= r_count;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                    r_state <= S_SRD;
                end
                S_PICK: begin
                    r_st <= ST_DONE;
                    if (r_found) begin
                        r_da <= 16'(r_pent.start + 16'(HEADER_BYTES));
                        if (left > 17'(HEADER_BYTES) && r_count < CNT_W'(MAX_BLOCKS)) begin
                            r_gb    <= r_size;
                            r_i     <= r_count - 1'b1;
                            r_state <= S_SHRD;
                        end else begin
                            r_gb    <= r_pent.len;
                            r_state <= S_OUT;
                        end
                    end else if (r_count >= CNT_W'(MAX_BLOCKS)) begin
                        r_st <= ST_TABLE; r_state <= S_OUT;
                    end else if (grow_end > {1'b0, hend}) begin
                        r_st <= ST_HEAP; r_state <= S_OUT;
                    end else begin
                        r_da    <= 16'(r_top[15:0] + 16'(HEADER_BYTES));
                        r_gb    <= r_size;
                        r_top   <= grow_end[16:0];
                        r_count <= r_count + 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_SHRD: r_state <= (r_i == CNT_W'(r_pick)) ? S_SPLIT : S_SHWR;
                S_SHWR: begin
                    r_i <= r_i - 1'b1;
                    r_state <= S_SHRD;
                end
                S_SPLIT: begin
                    r_count <= r_count + 1'b1;
                    r_state <= S_OUT;
                end
                S_MRD: r_state <= (r_i == r_count) ? S_FLUSH : S_MCHK;
                S_MCHK: begin
                    t_entry e;
                    e = rd;
                    if (r_mode && 16'(rd.start + 16'(HEADER_BYTES)) == r_addr) begin
                        if (rd.free) begin
                            r_st <= ST_BAD; r_state <= S_OUT;
                        end else begin
                            r_st <= ST_DONE;
                            r_gb <= rd.len;
                            r_mode <= 1'b0;
                        end
                        e.free = 1'b1;
                    end
                    if (!(r_mode && 16'(rd.start + 16'(HEADER_BYTES)) == r_addr && rd.free)) begin
                        if (r_have && r_acc.free && e.free) begin
                            r_acc.len <= 17'(r_acc.len + 17'(HEADER_BYTES) + e.len);
                        end else begin
                            if (r_have) r_w <= r_w + 1'b1;
                            r_acc  <= e;
                            r_have <= 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                        r_state <= S_MRD;
                    end
                end
                S_FLUSH: begin
                    if (r_mode) begin
                        r_st <= ST_BAD;
                    end else begin
                        r_count <= r_w + 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
